### src/pmd_pkg.sv
// Package with shared types and constants of the PS/2 mouse packet decoder.
`timescale 1ns / 1ps

package pmd_pkg;

   localparam logic [7:0] OVERFLOW_MASK = 8'hC0;
   localparam int         SYNC_BIT      = 3;
   localparam logic [7:0] BUTTON_MASK   = 8'h07;
   localparam logic [7:0] WHEEL_MASK    = 8'h0F;
   localparam logic [7:0] WHEEL_UPPER   = 8'hF0;

   localparam logic [2:0] BTN_NONE        = 3'd0;
   localparam logic [2:0] BTN_LEFT        = 3'd1;
   localparam logic [2:0] BTN_RIGHT       = 3'd2;
   localparam logic [2:0] BTN_MIDDLE      = 3'd3;
   localparam logic [2:0] BTN_SCROLL_UP   = 3'd4;
   localparam logic [2:0] BTN_SCROLL_DOWN = 3'd5;

   localparam logic [1:0] EV_MOVE     = 2'd0;
   localparam logic [1:0] EV_PRESSED  = 2'd1;
   localparam logic [1:0] EV_RELEASED = 2'd2;

   typedef struct packed {
      logic [2:0] code;
      logic [1:0] state;
   } event_type;

   typedef struct packed {
      logic signed [7:0] delta_x;
      logic signed [8:0] delta_y;
      event_type         ev0;
      event_type         ev1;
      logic              two;
   } entry_type;

endpackage

### src/ps2_mouse_packet_decoder.sv
// Top level of the PS/2 mouse packet decoder.
`timescale 1ns / 1ps

// Takes one mouse byte per cycle on req and gives scroll, button and move words on rsp. A
// packet of three bytes, or four when wheel mode is set, yields zero, one or two words,
// one per cycle from the output register unless stalled; a two-entry packet queue sits
// between the front end and the output stage, so the sustained rate is one byte per cycle
// up to two words per packet, bounded by the single output register. req_stall rises only
// while the queue is full. Write wheel mode through csr only while the block is idle.
module ps2_mouse_packet_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [7:0] rsp_delta_x,
   output logic signed [8:0] rsp_delta_y,
   output logic [2:0]        rsp_button_code,
   output logic [1:0]        rsp_event_state,
   output logic              rsp_last_of_run,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wdata
);

   logic               push_valid, q_full, q_not_empty, q_pop;
   pmd_pkg::entry_type push_data, q_data;

   assign req_stall = q_full;
   assign csr_ready = 1'b1;

   pmd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .csr_valid   (csr_valid && csr_ready),
      .csr_wdata   (csr_wdata),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   pmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .pop_data   (q_data)
   );

   pmd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_delta_x     (rsp_delta_x),
      .rsp_delta_y     (rsp_delta_y),
      .rsp_button_code (rsp_button_code),
      .rsp_event_state (rsp_event_state),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

### src/pmd_front.sv
// Front end: gathers packet bytes, tracks buttons and classifies each packet into events.
`timescale 1ns / 1ps

module pmd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               csr_valid,
   input  logic               csr_wdata,
   output logic               push_valid,
   output pmd_pkg::entry_type push_data
);

   logic [1:0] pos_ff, pos_in;
   logic [2:0] held_ff, held_in;
   logic       mode_ff, mode_in;
   logic [7:0] bytes_ff [4];

   logic       accept, start_ok, done, overflow, scroll, second, btn_change;
   logic [7:0] b0, b1, b2, b3;
   logic [2:0] buttons, changed;
   logic [3:0] wheel;
   pmd_pkg::event_type scroll_ev, second_ev;

   always_comb begin
      accept   = req_valid && !req_stall;
      start_ok = (pos_ff != 2'd0) || req_rx_byte[pmd_pkg::SYNC_BIT];
      done     = mode_ff ? (pos_ff == 2'd3) : (pos_ff >= 2'd2);

      b0 = bytes_ff[0];
      b1 = bytes_ff[1];
      b2 = (pos_ff == 2'd2) ? req_rx_byte : bytes_ff[2];
      b3 = (pos_ff == 2'd3) ? req_rx_byte : bytes_ff[3];

      overflow   = (b0 & pmd_pkg::OVERFLOW_MASK) != 8'h00;
      buttons    = b0[2:0] & pmd_pkg::BUTTON_MASK[2:0];
      changed    = buttons ^ held_ff;
      btn_change = changed != 3'b000;
      wheel      = b3[3:0] & pmd_pkg::WHEEL_MASK[3:0];
      scroll     = mode_ff && (wheel != 4'h0);

      scroll_ev.code  = wheel[3] ? pmd_pkg::BTN_SCROLL_DOWN : pmd_pkg::BTN_SCROLL_UP;
      scroll_ev.state = pmd_pkg::EV_MOVE;

      second_ev.code  = pmd_pkg::BTN_NONE;
      second_ev.state = pmd_pkg::EV_MOVE;
      if (changed[0]) begin
         second_ev.code  = pmd_pkg::BTN_LEFT;
         second_ev.state = buttons[0] ? pmd_pkg::EV_PRESSED : pmd_pkg::EV_RELEASED;
      end else if (changed[1]) begin
         second_ev.code  = pmd_pkg::BTN_RIGHT;
         second_ev.state = buttons[1] ? pmd_pkg::EV_PRESSED : pmd_pkg::EV_RELEASED;
      end else if (changed[2]) begin
         second_ev.code  = pmd_pkg::BTN_MIDDLE;
         second_ev.state = buttons[2] ? pmd_pkg::EV_PRESSED : pmd_pkg::EV_RELEASED;
      end
      second = btn_change || (b1 != 8'h00) || (b2 != 8'h00);

      push_data.delta_x = b1;
      push_data.delta_y = 9'sd0 - $signed({b2[7], b2});
      push_data.ev0     = scroll ? scroll_ev : second_ev;
      push_data.ev1     = second_ev;
      push_data.two     = scroll && second;

      push_valid = accept && start_ok && done && !overflow && (scroll || second);

      pos_in  = pos_ff;
      held_in = held_ff;
      if (accept && start_ok) begin
         pos_in = done ? 2'd0 : pos_ff + 2'd1;
         if (done && !overflow) begin
            held_in = buttons;
         end
      end
      mode_in = csr_valid ? csr_wdata : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 2'd0;
         held_ff <= 3'd0;
         mode_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         held_ff <= held_in;
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && start_ok) begin
         bytes_ff[pos_ff] <= req_rx_byte;
      end
   end

endmodule

### src/pmd_queue.sv
// Two-entry queue of classified packets between the front and back ends.
`timescale 1ns / 1ps

module pmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  pmd_pkg::entry_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output pmd_pkg::entry_type pop_data
);

   pmd_pkg::entry_type slots_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full      = count_ff == 2'd2;
      not_empty = count_ff != 2'd0;
      pop_data  = slots_ff[rd_ff];
      wr_in     = push_valid ? ~wr_ff : wr_ff;
      rd_in     = pop ? ~rd_ff : rd_ff;
      count_in  = count_ff + {1'b0, push_valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ff] <= push_data;
      end
   end

endmodule

### src/pmd_back.sv
// Back end: sends the one or two events of each packet through the output register.
`timescale 1ns / 1ps

module pmd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  pmd_pkg::entry_type  q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [7:0]   rsp_delta_x,
   output logic signed [8:0]   rsp_delta_y,
   output logic [2:0]          rsp_button_code,
   output logic [1:0]          rsp_event_state,
   output logic                rsp_last_of_run
);

   logic               valid_ff, valid_in, pend_ff, pend_in, load;
   logic               last_ff, last_in;
   logic signed [7:0]  dx_ff, dx_in;
   logic signed [8:0]  dy_ff, dy_in;
   pmd_pkg::event_type ev_ff, ev_in, next_ev_ff, next_ev_in;

   always_comb begin
      load       = !valid_ff || !rsp_stall;
      q_pop      = 1'b0;
      valid_in   = valid_ff;
      pend_in    = pend_ff;
      last_in    = last_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      ev_in      = ev_ff;
      next_ev_in = next_ev_ff;
      if (load) begin
         if (pend_ff) begin
            valid_in = 1'b1;
            ev_in    = next_ev_ff;
            last_in  = 1'b1;
            pend_in  = 1'b0;
         end else if (q_not_empty) begin
            q_pop      = 1'b1;
            valid_in   = 1'b1;
            dx_in      = q_data.delta_x;
            dy_in      = q_data.delta_y;
            ev_in      = q_data.ev0;
            next_ev_in = q_data.ev1;
            last_in    = !q_data.two;
            pend_in    = q_data.two;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff    <= last_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      ev_ff      <= ev_in;
      next_ev_ff <= next_ev_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_delta_x     = dx_ff;
   assign rsp_delta_y     = dy_ff;
   assign rsp_button_code = ev_ff.code;
   assign rsp_event_state = ev_ff.state;
   assign rsp_last_of_run = last_ff;

endmodule

### tb/tb_ps2_mouse_packet_decoder.sv
// Self-checking testbench for the PS/2 mouse packet decoder, with directed and random bytes.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_decoder;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int PHASE_BYTES    = 137;

   typedef struct packed {
      logic signed [7:0] dx;
      logic signed [8:0] dy;
      logic [2:0]        code;
      logic [1:0]        state;
      logic              last;
   } mouse_event_type;

   typedef enum logic {ROW_BYTE, ROW_MODE} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      logic [7:0]      data;
      logic            typed;
      logic            count;
      mouse_event_type ev;
   } stim_row_type;

   localparam mouse_event_type NO_EVENT  = '0;
   localparam stim_row_type    PREDICTED = '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_EVENT};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_rx_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [7:0] rsp_delta_x;
   logic signed [8:0] rsp_delta_y;
   logic [2:0]        rsp_button_code;
   logic [1:0]        rsp_event_state;
   logic              rsp_last_of_run;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_wdata = 1'b0;

   logic [7:0]      pkt_bytes [4];
   logic [1:0]      pkt_pos = 2'd0;
   logic [2:0]      buttons_held = 3'd0;
   logic            wheel_mode = 1'b0;
   mouse_event_type pending_mouse_events [$];

   int unsigned send_idle_pct = 12;
   int unsigned stall_pct = 12;
   int          bytes_taken = 0;
   int          error_count = 0;
   int          quiet_cycles = 0;

   stim_row_type directed_rows [27] = '{
      '{ROW_BYTE, 8'h00, 1'b1, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h09, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h7F, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h80, 1'b1, 1'b1,
        '{8'sd127, 9'sd128, pmd_pkg::BTN_LEFT, pmd_pkg::EV_PRESSED, 1'b1}},
      '{ROW_BYTE, 8'hC8, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h01, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h01, 1'b1, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h08, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h80, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h7F, 1'b1, 1'b1,
        '{8'h80, -9'sd127, pmd_pkg::BTN_LEFT, pmd_pkg::EV_RELEASED, 1'b1}},
      '{ROW_BYTE, 8'h0E, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h05, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'hFB, 1'b0, 1'b0, NO_EVENT},
      '{ROW_MODE, 8'h01, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h08, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h01, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h08, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h01, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h08, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h08, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h02, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'h03, 1'b0, 1'b0, NO_EVENT},
      '{ROW_MODE, 8'h00, 1'b0, 1'b0, NO_EVENT},
      '{ROW_BYTE, 8'hF0, 1'b0, 1'b0, NO_EVENT}
   };

   ps2_mouse_packet_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_delta_x     (rsp_delta_x),
      .rsp_delta_y     (rsp_delta_y),
      .rsp_button_code (rsp_button_code),
      .rsp_event_state (rsp_event_state),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic decode_mouse_byte(input logic [7:0] value, input bit record,
                                    output bit taken);
      logic [1:0]        end_pos;
      logic [7:0]        masked;
      logic [2:0]        buttons;
      logic [2:0]        changed;
      logic [3:0]        wheel;
      logic signed [7:0] dx;
      logic signed [8:0] dy;
      logic [1:0]        press;
      mouse_event_type   evs [$];
      taken = 1'b0;
      end_pos = wheel_mode ? 2'd3 : 2'd2;
      if (pkt_pos == 2'd0 && !value[pmd_pkg::SYNC_BIT]) return;
      taken = 1'b1;
      pkt_bytes[pkt_pos] = value;
      if (pkt_pos < end_pos) begin
         pkt_pos = pkt_pos + 2'd1;
         return;
      end
      pkt_pos = 2'd0;
      if ((pkt_bytes[0] & pmd_pkg::OVERFLOW_MASK) != 8'd0) return;
      dx = pkt_bytes[1];
      dy = -$signed({pkt_bytes[2][7], pkt_bytes[2]});
      masked = pkt_bytes[0] & pmd_pkg::BUTTON_MASK;
      buttons = masked[2:0];
      changed = buttons ^ buttons_held;
      buttons_held = buttons;
      if (wheel_mode) begin
         masked = pkt_bytes[3] & pmd_pkg::WHEEL_MASK;
         wheel = masked[3:0];
         if (wheel != 4'd0)
            evs.push_back('{dx, dy,
                            wheel[3] ? pmd_pkg::BTN_SCROLL_DOWN : pmd_pkg::BTN_SCROLL_UP,
                            pmd_pkg::EV_MOVE, 1'b0});
      end
      if (changed[0]) begin
         press = buttons[0] ? pmd_pkg::EV_PRESSED : pmd_pkg::EV_RELEASED;
         evs.push_back('{dx, dy, pmd_pkg::BTN_LEFT, press, 1'b0});
      end else if (changed[1]) begin
         press = buttons[1] ? pmd_pkg::EV_PRESSED : pmd_pkg::EV_RELEASED;
         evs.push_back('{dx, dy, pmd_pkg::BTN_RIGHT, press, 1'b0});
      end else if (changed[2]) begin
         press = buttons[2] ? pmd_pkg::EV_PRESSED : pmd_pkg::EV_RELEASED;
         evs.push_back('{dx, dy, pmd_pkg::BTN_MIDDLE, press, 1'b0});
      end else if (dx != 0 || dy != 0) begin
         evs.push_back('{dx, dy, pmd_pkg::BTN_NONE, pmd_pkg::EV_MOVE, 1'b0});
      end
      if (evs.size() != 0) evs[evs.size() - 1].last = 1'b1;
      if (record) foreach (evs[i]) pending_mouse_events.push_back(evs[i]);
   endtask

   task automatic send_byte(input logic [7:0] value, input stim_row_type row);
      bit taken;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_stall);
      decode_mouse_byte(value, !row.typed, taken);
      if (row.typed && row.count) pending_mouse_events.push_back(row.ev);
      if (taken) bytes_taken++;
      @(negedge clock);
   endtask

   task automatic drain_mouse_events();
      req_valid <= 1'b0;
      while (pending_mouse_events.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_wheel_mode(input logic mode);
      drain_mouse_events();
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      do @(posedge clock); while (!csr_ready);
      wheel_mode = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_packet();
      logic [7:0] head;
      logic [7:0] body [3];
      if ($urandom_range(99, 0) < 15) begin
         send_byte(8'($urandom_range(255, 0)), PREDICTED);
         return;
      end
      while (pkt_pos != 2'd0) send_byte(8'($urandom_range(255, 0)), PREDICTED);
      head = 8'($urandom_range(255, 0));
      head[pmd_pkg::SYNC_BIT] = 1'b1;
      if ($urandom_range(9, 0) != 0) head[7:6] = 2'b00;
      if ($urandom_range(3, 0) == 0) head[2:0] = buttons_held;
      foreach (body[i])
         body[i] = ($urandom_range(3, 0) == 0) ? 8'h00 : 8'($urandom_range(255, 0));
      send_byte(head, PREDICTED);
      send_byte(body[0], PREDICTED);
      send_byte(body[1], PREDICTED);
      if (wheel_mode) send_byte(body[2], PREDICTED);
   endtask

   task automatic compare_field(input string name, input logic signed [9:0] want,
                                input logic signed [9:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99, 0) < stall_pct);

   always @(posedge clock) begin
      mouse_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_mouse_events.size() == 0) begin
            $display("%0t ns: unexpected word, expected none, actual %0d %0d %0d %0d %0d",
                     $time, rsp_delta_x, rsp_delta_y, rsp_button_code,
                     rsp_event_state, rsp_last_of_run);
            error_count++;
         end else begin
            want = pending_mouse_events.pop_front();
            compare_field("delta_x", want.dx, rsp_delta_x);
            compare_field("delta_y", want.dy, rsp_delta_y);
            compare_field("button_code", want.code, rsp_button_code);
            compare_field("event_state", want.state, rsp_event_state);
            compare_field("last_of_run", want.last, rsp_last_of_run);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int target;
      int halfway;
      bit paused;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_MODE)
            write_wheel_mode(directed_rows[i].data[0]);
         else
            send_byte(directed_rows[i].data, directed_rows[i]);
      end
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 66;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 66;
            end
            default: begin
               send_idle_pct = 12;
               stall_pct = 12;
            end
         endcase
         write_wheel_mode(!wheel_mode);
         target = bytes_taken + PHASE_BYTES;
         halfway = bytes_taken + PHASE_BYTES / 2;
         paused = 1'b0;
         while (bytes_taken < target) begin
            send_random_packet();
            if (!paused && bytes_taken >= halfway) begin
               drain_mouse_events();
               paused = 1'b1;
            end
         end
      end
      drain_mouse_events();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
src/pmd_pkg.sv
src/pmd_front.sv
src/pmd_queue.sv
src/pmd_back.sv
src/ps2_mouse_packet_decoder.sv
tb/tb_ps2_mouse_packet_decoder.sv
